>>> rtl/rctv_pkg.sv
`timescale 1ns / 1ps

package rctv_pkg;

	localparam int unsigned CharWidth = 8;

	localparam logic [CharWidth-1:0] CH_NUL    = 8'h00;
	localparam logic [CharWidth-1:0] CH_LBRACK = 8'h5B;
	localparam logic [CharWidth-1:0] CH_RBRACK = 8'h5D;
	localparam logic [CharWidth-1:0] CH_CARET  = 8'h5E;
	localparam logic [CharWidth-1:0] CH_DASH   = 8'h2D;
	localparam logic [CharWidth-1:0] CH_BSLASH = 8'h5C;
	localparam logic [CharWidth-1:0] CH_PRINT_LO = 8'h20;
	localparam logic [CharWidth-1:0] CH_PRINT_HI = 8'h7E;

	typedef logic [CharWidth-1:0] char_t;

	// parser position, one-hot
	typedef enum logic [7:0] {
		PH_START  = 8'b0000_0001,
		PH_SINGLE = 8'b0000_0010,
		PH_ESC1   = 8'b0000_0100,
		PH_ESC2   = 8'b0000_1000,
		PH_OPEN   = 8'b0001_0000,
		PH_BODY   = 8'b0010_0000,
		PH_CLOSED = 8'b0100_0000,
		PH_BAD    = 8'b1000_0000
	} phase_t;

	// number of class bytes held for range windows
	typedef logic [1:0] held_cnt_t;

endpackage

>>> rtl/regex_char_token_validator.sv
`timescale 1ns / 1ps

// Character-token validator for a small regex front end.
// Input channel (in_valid / in_ready / char_code): one byte of the token per
//   word; a zero byte ends the token.
// Output channel (out_valid / out_ready / token_valid): one word per token,
//   produced by the zero byte, giving 1 if the token was a valid character
//   string (single printable, escape pair, or a closed non-empty bracket class
//   with ordered ranges). Non-zero bytes produce no output word.
// Result path: a terminator passes the input register, then the result register.
// Throughput: one word per cycle unless a terminator waits on a stalled result;
//   the parser state is a handful of flops updated by short logic between the
//   input and result registers.
// Stall: while a result waits in the result register, non-zero bytes keep
//   flowing. A terminator behind it waits in the input register, and in_ready
//   stays low until the result slot frees.
// Reset (arst_n low, asynchronous): both registers empty, parser back at the
//   start of a token with all held bytes and flags cleared.

module regex_char_token_validator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [rctv_pkg::CharWidth-1:0] char_code,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       token_valid
);

	// input register
	logic               vld_s1;
	rctv_pkg::char_t    char_s1;

	// parser state
	rctv_pkg::phase_t   phase_q,  phase_d;
	rctv_pkg::char_t    first_q,  first_d;
	rctv_pkg::char_t    second_q, second_d;
	rctv_pkg::held_cnt_t cnt_q,   cnt_d;
	logic               nonempty_q, nonempty_d;
	logic               failed_q,   failed_d;

	// result register
	logic               out_vld_q;
	logic               res_q;
	logic               res_d;

	logic               is_term;
	logic               s1_adv;
	logic               class_go;

	assign is_term  = (char_s1 == rctv_pkg::CH_NUL);
	// a terminator only moves on when the result slot is free or draining
	assign s1_adv   = vld_s1 && (!is_term || !out_vld_q || out_ready);
	assign in_ready = !vld_s1 || s1_adv;

	assign out_valid   = out_vld_q;
	assign token_valid = res_q;

	// class bytes: anything but ']' in the body, and not a leading '^' either
	assign class_go = (phase_q == rctv_pkg::PH_BODY && char_s1 != rctv_pkg::CH_RBRACK) ||
		(phase_q == rctv_pkg::PH_OPEN && char_s1 != rctv_pkg::CH_RBRACK &&
		 char_s1 != rctv_pkg::CH_CARET);

	always_comb begin
		phase_d    = phase_q;
		first_d    = first_q;
		second_d   = second_q;
		cnt_d      = cnt_q;
		nonempty_d = nonempty_q;
		failed_d   = failed_q;
		res_d      = 1'b0;
		if (is_term) begin
			unique case (phase_q)
				rctv_pkg::PH_SINGLE: begin
					res_d = (first_q >= rctv_pkg::CH_PRINT_LO) &&
						(first_q <= rctv_pkg::CH_PRINT_HI) &&
						(first_q != rctv_pkg::CH_BSLASH) &&
						(first_q != rctv_pkg::CH_LBRACK);
				end
				rctv_pkg::PH_ESC2:   res_d = 1'b1;
				rctv_pkg::PH_CLOSED: res_d = nonempty_q && !failed_q;
				default:             res_d = 1'b0;
			endcase
			phase_d    = rctv_pkg::PH_START;
			first_d    = '0;
			second_d   = '0;
			cnt_d      = '0;
			nonempty_d = 1'b0;
			failed_d   = 1'b0;
		end else begin
			unique case (phase_q)
				rctv_pkg::PH_START: begin
					if (char_s1 == rctv_pkg::CH_LBRACK) begin
						phase_d = rctv_pkg::PH_OPEN;
					end else if (char_s1 == rctv_pkg::CH_BSLASH) begin
						phase_d = rctv_pkg::PH_ESC1;
					end else begin
						first_d = char_s1;
						phase_d = rctv_pkg::PH_SINGLE;
					end
				end
				rctv_pkg::PH_ESC1: phase_d = rctv_pkg::PH_ESC2;
				rctv_pkg::PH_OPEN: begin
					if (char_s1 == rctv_pkg::CH_RBRACK) begin
						phase_d = rctv_pkg::PH_CLOSED;
					end else begin
						phase_d = rctv_pkg::PH_BODY;
					end
				end
				rctv_pkg::PH_BODY: begin
					if (char_s1 == rctv_pkg::CH_RBRACK) begin
						phase_d = rctv_pkg::PH_CLOSED;
					end
				end
				default: phase_d = rctv_pkg::PH_BAD;
			endcase

			// greedy three-byte range window
			if (class_go) begin
				nonempty_d = 1'b1;
				case (cnt_q)
					2'd0: begin
						first_d = char_s1;
						cnt_d   = 2'd1;
					end
					2'd1: begin
						second_d = char_s1;
						cnt_d    = 2'd2;
					end
					default: begin
						if (second_q == rctv_pkg::CH_DASH) begin
							if ($signed(first_q) > $signed(char_s1)) begin
								failed_d = 1'b1;
							end
							cnt_d = 2'd0;
						end else begin
							first_d  = second_q;
							second_d = char_s1;
						end
					end
				endcase
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_code;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= rctv_pkg::PH_START;
			first_q    <= '0;
			second_q   <= '0;
			cnt_q      <= '0;
			nonempty_q <= 1'b0;
			failed_q   <= 1'b0;
		end else if (s1_adv) begin
			phase_q    <= phase_d;
			first_q    <= first_d;
			second_q   <= second_d;
			cnt_q      <= cnt_d;
			nonempty_q <= nonempty_d;
			failed_q   <= failed_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_adv && is_term) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && is_term) begin
			res_q <= res_d;
		end
	end

	// a terminator leaving the input register always lands a result
	a_term_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && is_term) |=> out_vld_q)
		else $error("terminator did not produce a result word");

	// parser is back at token start after a terminator
	a_term_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && is_term) |=> (phase_q == rctv_pkg::PH_START && cnt_q == 2'd0 &&
		 !failed_q && !nonempty_q))
		else $error("parser state not cleared after terminator");

	// input only blocks behind a held terminator and a stalled result
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (vld_s1 && is_term && out_vld_q && !out_ready))
		else $error("input stalled without cause");

	// window never holds more than two bytes
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("held byte count out of range");

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

// Token validator bench: bytes go in one word at a time, and one verdict word comes
// back per zero byte. A directed table is walked first, then random tokens, mostly
// well formed.
module tb;

	// how a row's verdict is known: from the parser copy, or typed into the table
	typedef enum logic [1:0] {
		CHK_PRED = 2'd0,
		CHK_ZERO = 2'd1,
		CHK_ONE  = 2'd2
	} chk_t;

	typedef struct packed {
		logic [7:0] code;
		chk_t       chk;
	} dir_row_t;

	localparam int DIR_LEN     = 33;
	localparam int RAND_ITEMS  = 1800;
	localparam int HOLD_AT     = DIR_LEN + 200;   // receiver freezes here
	localparam int HOLD_CYCLES = 300;
	localparam int PAUSE_AT    = DIR_LEN + 700;   // sender drains here
	localparam int CALM_LO     = DIR_LEN + 1000;  // no idling on either side
	localparam int CALM_HI     = DIR_LEN + 1300;
	localparam int QUIET_LIMIT = 3000;            // well over the freeze

	// Directed table. Verdicts are typed in where they are obvious.
	localparam dir_row_t DIR_TAB [0:DIR_LEN-1] = '{
		'{8'h00, CHK_ZERO},                            // empty token
		'{8'h7E, CHK_PRED}, '{8'h00, CHK_ONE},         // top printable
		'{8'h20, CHK_PRED}, '{8'h00, CHK_ONE},         // bottom printable
		'{8'hFF, CHK_PRED}, '{8'h00, CHK_ZERO},        // high byte, not printable
		'{8'h5C, CHK_PRED}, '{8'h00, CHK_ZERO},        // lone backslash
		'{8'h5C, CHK_PRED}, '{8'h5D, CHK_PRED},
		'{8'h00, CHK_ONE},                             // escape pair
		'{8'h5B, CHK_PRED}, '{8'h00, CHK_ZERO},        // lone open bracket
		'{8'h5B, CHK_PRED}, '{8'h5D, CHK_PRED},
		'{8'h00, CHK_ZERO},                            // empty class
		'{8'h5B, CHK_PRED}, '{8'h5E, CHK_PRED}, '{8'h5D, CHK_PRED},
		'{8'h00, CHK_ZERO},                            // empty negated class
		'{8'h5B, CHK_PRED}, '{8'h5E, CHK_PRED}, '{8'h7F, CHK_PRED},
		'{8'h2D, CHK_PRED}, '{8'h80, CHK_PRED}, '{8'h5D, CHK_PRED},
		'{8'h00, CHK_PRED},                            // range reversed as signed
		'{8'h5B, CHK_PRED}, '{8'h61, CHK_PRED}, '{8'h5D, CHK_PRED},
		'{8'h62, CHK_PRED}, '{8'h00, CHK_ZERO}         // trailing byte after class
	};

	logic            clk;
	logic            arst_n;
	logic            in_valid;
	logic            in_ready;
	rctv_pkg::char_t char_code;
	logic            out_valid;
	logic            out_ready;
	logic            token_valid;

	regex_char_token_validator u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.char_code   (char_code),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.token_valid (token_valid)
	);

	// stimulus store and expected verdicts
	rctv_pkg::char_t stim_code [$];
	chk_t            stim_chk [$];
	logic            verdict_q [$];
	chk_t            cur_chk;

	int    mismatches     = 0;
	int    quiet_cycles   = 0;
	int    tokens_checked = 0;
	int    tokens_good    = 0;
	int    bytes_taken    = 0;
	bit    rst_done       = 1'b0;
	bit    calm           = 1'b0;
	bit    hold_start     = 1'b0;

	// parser copy
	rctv_pkg::phase_t    ph       = rctv_pkg::PH_START;
	rctv_pkg::char_t     held_a   = '0;
	rctv_pkg::char_t     held_b   = '0;
	rctv_pkg::held_cnt_t held_n   = '0;
	logic                cls_seen = 1'b0;
	logic                rng_bad  = 1'b0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic void clear_parser();
		ph       = rctv_pkg::PH_START;
		held_a   = '0;
		held_b   = '0;
		held_n   = '0;
		cls_seen = 1'b0;
		rng_bad  = 1'b0;
	endfunction

	// greedy range scan over class bytes: a '-' b windows must be ordered as signed
	function automatic void take_class_byte(input rctv_pkg::char_t c);
		cls_seen = 1'b1;
		case (held_n)
			2'd0: begin
				held_a = c;
				held_n = 2'd1;
			end
			2'd1: begin
				held_b = c;
				held_n = 2'd2;
			end
			default: begin
				if (held_b == rctv_pkg::CH_DASH) begin
					if ($signed(held_a) > $signed(c))
						rng_bad = 1'b1;
					held_n = 2'd0;
				end else begin
					held_a = held_b;
					held_b = c;
				end
			end
		endcase
	endfunction

	function automatic void parse_byte(input rctv_pkg::char_t c, output logic ends,
		output logic verdict);
		ends    = 1'b0;
		verdict = 1'b0;
		if (c == rctv_pkg::CH_NUL) begin
			ends = 1'b1;
			case (ph)
				rctv_pkg::PH_SINGLE: verdict = (held_a >= rctv_pkg::CH_PRINT_LO) &&
					(held_a <= rctv_pkg::CH_PRINT_HI) &&
					(held_a != rctv_pkg::CH_BSLASH) && (held_a != rctv_pkg::CH_LBRACK);
				rctv_pkg::PH_ESC2:   verdict = 1'b1;
				rctv_pkg::PH_CLOSED: verdict = cls_seen && !rng_bad;
				default:             verdict = 1'b0;
			endcase
			clear_parser();
		end else begin
			case (ph)
				rctv_pkg::PH_START: begin
					if (c == rctv_pkg::CH_LBRACK)
						ph = rctv_pkg::PH_OPEN;
					else if (c == rctv_pkg::CH_BSLASH)
						ph = rctv_pkg::PH_ESC1;
					else begin
						held_a = c;
						ph = rctv_pkg::PH_SINGLE;
					end
				end
				rctv_pkg::PH_ESC1: ph = rctv_pkg::PH_ESC2;
				rctv_pkg::PH_OPEN: begin
					if (c == rctv_pkg::CH_RBRACK)
						ph = rctv_pkg::PH_CLOSED;
					else if (c == rctv_pkg::CH_CARET)
						ph = rctv_pkg::PH_BODY;
					else begin
						take_class_byte(c);
						ph = rctv_pkg::PH_BODY;
					end
				end
				rctv_pkg::PH_BODY: begin
					if (c == rctv_pkg::CH_RBRACK)
						ph = rctv_pkg::PH_CLOSED;
					else
						take_class_byte(c);
				end
				default: ph = rctv_pkg::PH_BAD;
			endcase
		end
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic add_item(input rctv_pkg::char_t b, input chk_t k);
		stim_code.push_back(b);
		stim_chk.push_back(k);
	endtask

	// any class byte: neither zero nor ']', sometimes one of the markers
	function automatic rctv_pkg::char_t rand_class_byte();
		rctv_pkg::char_t b;
		case ($urandom_range(7))
			0: b = rctv_pkg::CH_DASH;
			1: b = rctv_pkg::CH_CARET;
			2: b = rctv_pkg::CH_LBRACK;
			3: b = rctv_pkg::CH_BSLASH;
			default: begin
				do
					b = rctv_pkg::char_t'($urandom_range(1, 255));
				while (b == rctv_pkg::CH_RBRACK);
			end
		endcase
		return b;
	endfunction

	task automatic add_random_token();
		int              kind;
		int              n;
		rctv_pkg::char_t lo;
		rctv_pkg::char_t hi;
		rctv_pkg::char_t t;
		kind = $urandom_range(99);
		if (kind < 20) begin
			// single character, mostly printable
			if ($urandom_range(3) == 0)
				add_item(rctv_pkg::char_t'($urandom_range(1, 255)), CHK_PRED);
			else
				add_item(rctv_pkg::char_t'($urandom_range(rctv_pkg::CH_PRINT_LO,
					rctv_pkg::CH_PRINT_HI)), CHK_PRED);
		end else if (kind < 35) begin
			// escape, now and then a lone backslash or a surplus byte
			add_item(rctv_pkg::CH_BSLASH, CHK_PRED);
			if ($urandom_range(9) != 0)
				add_item(rctv_pkg::char_t'($urandom_range(1, 255)), CHK_PRED);
			if ($urandom_range(9) == 0)
				add_item(rctv_pkg::char_t'($urandom_range(1, 255)), CHK_PRED);
		end else if (kind < 85) begin
			// bracket class with ranges; a few unclosed or with trailing bytes
			add_item(rctv_pkg::CH_LBRACK, CHK_PRED);
			if ($urandom_range(2) == 0)
				add_item(rctv_pkg::CH_CARET, CHK_PRED);
			n = ($urandom_range(11) == 0) ? 0 : $urandom_range(1, 4);
			repeat (n) begin
				if ($urandom_range(1) == 0) begin
					lo = rand_class_byte();
					hi = rand_class_byte();
					if ($urandom_range(3) != 0 && $signed(lo) > $signed(hi)) begin
						t  = lo;
						lo = hi;
						hi = t;
					end
					add_item(lo, CHK_PRED);
					add_item(rctv_pkg::CH_DASH, CHK_PRED);
					add_item(hi, CHK_PRED);
				end else begin
					add_item(rand_class_byte(), CHK_PRED);
				end
			end
			if ($urandom_range(9) != 0)
				add_item(rctv_pkg::CH_RBRACK, CHK_PRED);
			if ($urandom_range(11) == 0)
				add_item(rctv_pkg::char_t'($urandom_range(1, 255)), CHK_PRED);
		end else begin
			// noise, empty token included
			n = $urandom_range(0, 6);
			repeat (n)
				add_item(rctv_pkg::char_t'($urandom_range(1, 255)), CHK_PRED);
		end
		add_item(rctv_pkg::CH_NUL, CHK_PRED);
	endtask

	// Scoreboard: predict on every accepted byte, compare every verdict word.
	always @(posedge clk) begin
		logic ends;
		logic verdict;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;

			if (in_valid && in_ready) begin
				bytes_taken++;
				parse_byte(char_code, ends, verdict);
				if (ends) begin
					if (cur_chk == CHK_ONE)
						verdict = 1'b1;
					else if (cur_chk == CHK_ZERO)
						verdict = 1'b0;
					verdict_q.push_back(verdict);
				end
			end

			if (out_valid && out_ready) begin
				if (verdict_q.size() == 0) begin
					report_mismatch($sformatf("verdict %b with no token pending", token_valid));
				end else begin
					verdict = verdict_q.pop_front();
					tokens_checked++;
					if (token_valid)
						tokens_good++;
					if (token_valid !== verdict)
						report_mismatch($sformatf("token_valid %b, wanted %b",
							token_valid, verdict));
				end
			end
		end
	end

	// Receiver: random back-pressure, one long freeze on request.
	initial begin : sink
		bit held;
		held      = 1'b0;
		out_ready = 1'b0;
		wait (rst_done);
		forever begin
			@(negedge clk);
			if (hold_start && !held) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_ready <= calm || ($urandom_range(99) >= 13);
		end
	end

	// Watchdog on handshake progress.
	initial begin : watchdog
		wait (rst_done);
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("watchdog: no handshake for %0d cycles, %0d verdicts outstanding",
			QUIET_LIMIT, verdict_q.size());
		$display("*** FAILED ***");
		$finish;
	end

	// Sender and run control.
	initial begin : source
		bit paused;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		char_code = '0;
		cur_chk   = CHK_PRED;
		paused    = 1'b0;

		for (int r = 0; r < DIR_LEN; r++)
			add_item(DIR_TAB[r].code, DIR_TAB[r].chk);
		while (stim_code.size() < DIR_LEN + RAND_ITEMS)
			add_random_token();

		repeat (10) @(negedge clk);
		arst_n   = 1'b1;
		rst_done = 1'b1;

		for (int i = 0; i < stim_code.size(); i++) begin
			calm = (i >= CALM_LO) && (i < CALM_HI);
			if (i == HOLD_AT)
				hold_start = 1'b1;
			while (!calm && $urandom_range(99) < 13) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
			in_valid  <= 1'b1;
			char_code <= stim_code[i];
			cur_chk   <= stim_chk[i];
			@(posedge clk);
			while (!in_ready)
				@(posedge clk);
			@(negedge clk);
			// drain once: stop offering until every verdict is back
			if (!paused && i >= PAUSE_AT && stim_code[i] == rctv_pkg::CH_NUL) begin
				paused = 1'b1;
				in_valid <= 1'b0;
				@(negedge clk);
				while (verdict_q.size() != 0)
					@(negedge clk);
			end
		end
		in_valid <= 1'b0;

		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d bytes in %0d tokens (%0d valid), directed table then random",
			bytes_taken, tokens_checked, tokens_good);
		$display("with a %0d-cycle receiver freeze, a full drain and a stall-free stretch",
			HOLD_CYCLES);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
